FILE: rtl/mpft_pkg.sv
// Shared widths, constants and types for the mapped page FIFO table.
package mpft_pkg;

    localparam int SLOTS_DEFAULT = 64;

    localparam int VA_W         = 64;
    localparam int PAGE_SHIFT   = 12;
    localparam int PAGE_W       = VA_W - PAGE_SHIFT;
    localparam int BASE_W       = 40;
    localparam int PHYS_W       = 41;
    localparam int SLOT_FIELD_W = 6;

    localparam int RESULT_W     = 1 + SLOT_FIELD_W + PHYS_W + 1 + PAGE_W;
    localparam int OUT_TDATA_W  = ((RESULT_W + 7) / 8) * 8;

    localparam int APB_DATA_W   = 64;
    localparam int APB_ADDR_W   = 1;
    localparam logic [APB_ADDR_W-1:0] REG_FRAME_BASE = 1'b0;

    // Per-cell control: rotate the ring or load a new page
    typedef struct packed {
        logic shift;
        logic load;
    } cell_ctrl_t;

endpackage

FILE: rtl/mpft_cell.sv
// One table cell: holds a page number, passes it along the ring or loads a new one.
module mpft_cell
(
    input  logic                        clk,
    input  mpft_pkg::cell_ctrl_t        ctrl,
    input  logic [mpft_pkg::PAGE_W-1:0] shift_in,
    input  logic [mpft_pkg::PAGE_W-1:0] load_data,
    output logic [mpft_pkg::PAGE_W-1:0] q
);

    logic [mpft_pkg::PAGE_W-1:0] page_reg;
    logic [mpft_pkg::PAGE_W-1:0] page_next;

    always_comb
    begin
        page_next = page_reg;
        if (ctrl.load)
        begin
            page_next = load_data;
        end
        else if (ctrl.shift)
        begin
            page_next = shift_in;
        end
    end

    always_ff @(posedge clk)
    begin
        page_reg <= page_next;
    end

    assign q = page_reg;

endmodule

FILE: rtl/mapped_page_fifo_table.sv
// Top level: ring of page cells, scan sequencer, result register and APB register.
//
// Each faulting address is reduced to its 4 KiB page number and compared against
// every valid entry as the ring of SLOTS cells rotates once past the head cell,
// one entry per cycle. A new page fills the lowest free slot; once the table is
// full the oldest slot is evicted in round-robin order. Each item passes through an
// accept state, a scan state that lasts one full ring rotation and an update state
// before the next item can be accepted; the update state waits while an earlier
// result is still held in the output register. The result register lets a new
// item be accepted while a finished result is not yet taken. No clearing pass is
// needed after reset. frame_base_page is at byte address 0.
module mapped_page_fifo_table
#(
    parameter int SLOTS = mpft_pkg::SLOTS_DEFAULT
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    // s_tdata: virtual_address[63:0]
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [mpft_pkg::VA_W-1:0]           s_tdata,
    // m_tdata: status[0], slot[6:1], physical_page[47:7], evicted[48],
    //          evicted_page[100:49], zero pad[103:101]
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [mpft_pkg::OUT_TDATA_W-1:0]    m_tdata,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [mpft_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [mpft_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [mpft_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                pready
);

    localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam logic [SW-1:0] LAST_SLOT = SW'(SLOTS - 1);
    localparam int PW = mpft_pkg::PAGE_W;

    typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_DONE} state_t;

    // ---------------- configuration ----------------
    logic [mpft_pkg::BASE_W-1:0] base_reg;
    logic [mpft_pkg::BASE_W-1:0] base_next;

    assign pready = 1'b1;

    always_comb
    begin
        base_next = base_reg;
        if (psel && penable && pwrite && pready && (paddr == mpft_pkg::REG_FRAME_BASE))
        begin
            base_next = pwdata[mpft_pkg::BASE_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg <= '0;
        end
        else
        begin
            base_reg <= base_next;
        end
    end

    assign prdata = (paddr == mpft_pkg::REG_FRAME_BASE)
                  ? {{(mpft_pkg::APB_DATA_W - mpft_pkg::BASE_W){1'b0}}, base_reg}
                  : '0;

    // ---------------- control state ----------------
    state_t            state_reg;
    logic [SW-1:0]     step_reg;
    logic [SW-1:0]     ptr_reg;
    logic              full_reg;
    logic [PW-1:0]     page_reg;
    logic              hit_reg;
    logic [SW-1:0]     hit_slot_reg;
    logic [PW-1:0]     victim_reg;

    logic              out_valid_reg;
    logic              out_status_reg;
    logic [mpft_pkg::SLOT_FIELD_W-1:0] out_slot_reg;
    logic [mpft_pkg::PHYS_W-1:0]       out_phys_reg;
    logic              out_evicted_reg;
    logic [PW-1:0]     out_evpage_reg;

    // ---------------- cell ring ----------------
    logic [PW-1:0]           cell_q [SLOTS];
    mpft_pkg::cell_ctrl_t    cell_ctrl [SLOTS];
    logic                    out_free;
    logic                    do_update;

    assign out_free  = !out_valid_reg || m_tready;
    assign do_update = (state_reg == ST_DONE) && out_free;

    for (genvar i = 0; i < SLOTS; i++)
    begin : g_cell
        always_comb
        begin
            cell_ctrl[i].shift = (state_reg == ST_SCAN);
            cell_ctrl[i].load  = do_update && !hit_reg && (ptr_reg == SW'(i));
        end

        mpft_cell u_cell
        (
            .clk       (clk),
            .ctrl      (cell_ctrl[i]),
            .shift_in  (cell_q[(i + 1) % SLOTS]),
            .load_data (page_reg),
            .q         (cell_q[i])
        );
    end

    // ---------------- scan and result ----------------
    logic                              head_valid;
    logic                              head_match;
    logic [SW-1:0]                     res_slot;
    logic [SW+mpft_pkg::SLOT_FIELD_W-1:0] res_slot_ext;
    logic [mpft_pkg::PHYS_W-1:0]       res_phys;
    logic [SW-1:0]                     ptr_inc;

    assign head_valid   = full_reg || (step_reg < ptr_reg);
    assign head_match   = head_valid && (cell_q[0] == page_reg);
    assign res_slot     = hit_reg ? hit_slot_reg : ptr_reg;
    assign res_slot_ext = {{mpft_pkg::SLOT_FIELD_W{1'b0}}, res_slot};
    assign res_phys     = {1'b0, base_reg}
                        + {{(mpft_pkg::PHYS_W - SW){1'b0}}, res_slot};
    assign ptr_inc      = (ptr_reg == LAST_SLOT) ? '0 : ptr_reg + SW'(1);

    assign s_tready = (state_reg == ST_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            step_reg        <= '0;
            ptr_reg         <= '0;
            full_reg        <= 1'b0;
            page_reg        <= '0;
            hit_reg         <= 1'b0;
            hit_slot_reg    <= '0;
            victim_reg      <= '0;
            out_valid_reg   <= 1'b0;
            out_status_reg  <= 1'b0;
            out_slot_reg    <= '0;
            out_phys_reg    <= '0;
            out_evicted_reg <= 1'b0;
            out_evpage_reg  <= '0;
        end
        else
        begin
            // a taken result is replaced directly when the update cycle reloads it
            if (out_valid_reg && m_tready && !do_update)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (s_tvalid)
                    begin
                        page_reg  <= s_tdata[mpft_pkg::VA_W-1:mpft_pkg::PAGE_SHIFT];
                        step_reg  <= '0;
                        hit_reg   <= 1'b0;
                        state_reg <= ST_SCAN;
                    end
                end
                ST_SCAN:
                begin
                    // head cell holds slot step_reg this cycle
                    if (head_match)
                    begin
                        hit_reg      <= 1'b1;
                        hit_slot_reg <= step_reg;
                    end
                    if (step_reg == ptr_reg)
                    begin
                        victim_reg <= cell_q[0];
                    end
                    if (step_reg == LAST_SLOT)
                    begin
                        state_reg <= ST_DONE;
                    end
                    else
                    begin
                        step_reg <= step_reg + SW'(1);
                    end
                end
                ST_DONE:
                begin
                    if (out_free)
                    begin
                        out_valid_reg   <= 1'b1;
                        out_status_reg  <= hit_reg;
                        out_slot_reg    <= res_slot_ext[mpft_pkg::SLOT_FIELD_W-1:0];
                        out_phys_reg    <= res_phys;
                        out_evicted_reg <= !hit_reg && full_reg;
                        out_evpage_reg  <= (!hit_reg && full_reg) ? victim_reg : '0;
                        if (!hit_reg)
                        begin
                            ptr_reg <= ptr_inc;
                            if (ptr_reg == LAST_SLOT)
                            begin
                                full_reg <= 1'b1;
                            end
                        end
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(mpft_pkg::OUT_TDATA_W - mpft_pkg::RESULT_W){1'b0}},
                       out_evpage_reg, out_evicted_reg, out_phys_reg,
                       out_slot_reg, out_status_reg};

`ifndef ASSERT_OFF
    a_full_sticks: assert property (@(posedge clk) disable iff (!rst_n)
        full_reg |=> full_reg)
        else $error("table full flag dropped");

    a_result_from_update: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(state_reg == ST_DONE))
        else $error("result appeared without an update cycle");

    a_evict_only_on_miss: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_evicted_reg) |-> (!out_status_reg && full_reg))
        else $error("eviction reported on a hit or before the table filled");

    a_scan_steps: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN && step_reg != LAST_SLOT)
            |=> (state_reg == ST_SCAN && step_reg == $past(step_reg) + SW'(1)))
        else $error("scan step counter skipped");
`endif

endmodule

FILE: tb/tb.sv
// Self-checking bench for mapped_page_fifo_table: page faults against a FIFO page-table predictor.
module tb;

    localparam int SLOTS        = mpft_pkg::SLOTS_DEFAULT;
    localparam int VA_W         = mpft_pkg::VA_W;
    localparam int PAGE_SHIFT   = mpft_pkg::PAGE_SHIFT;
    localparam int PAGE_W       = mpft_pkg::PAGE_W;
    localparam int BASE_W       = mpft_pkg::BASE_W;
    localparam int PHYS_W       = mpft_pkg::PHYS_W;
    localparam int SLOT_FIELD_W = mpft_pkg::SLOT_FIELD_W;
    localparam int RESULT_W     = mpft_pkg::RESULT_W;
    localparam int OUT_TDATA_W  = mpft_pkg::OUT_TDATA_W;
    localparam int APB_DATA_W   = mpft_pkg::APB_DATA_W;
    localparam int APB_ADDR_W   = mpft_pkg::APB_ADDR_W;
    localparam logic [APB_ADDR_W-1:0] REG_FRAME_BASE = mpft_pkg::REG_FRAME_BASE;
    localparam int MAX_WAIT     = 10;
    localparam int DRAIN_CYCLES = SLOTS + 8;
    localparam int STALL_LIMIT  = 1000;
    localparam int HISTORY_LEN  = 96;

    typedef struct packed {
        logic [PAGE_W-1:0]       evicted_page;
        logic                    evicted;
        logic [PHYS_W-1:0]       physical_page;
        logic [SLOT_FIELD_W-1:0] slot;
        logic                    status;
    } fault_result_t;

    typedef struct packed {
        logic [VA_W-1:0] addr;
        logic            hold;
    } fault_req_t;

    logic                   clk      = 1'b0;
    logic                   rst_n    = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [VA_W-1:0]        s_tdata  = '0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic                   psel     = 1'b0;
    logic                   penable  = 1'b0;
    logic                   pwrite   = 1'b0;
    logic [APB_ADDR_W-1:0]  paddr    = '0;
    logic [APB_DATA_W-1:0]  pwdata   = '0;
    logic [APB_DATA_W-1:0]  prdata;
    logic                   pready;

    // predictor state
    bit                     slot_valid [SLOTS];
    logic [PAGE_W-1:0]      slot_page  [SLOTS];
    int                     oldest_slot = 0;
    int                     fill_count  = 0;
    logic [BASE_W-1:0]      frame_base  = '0;

    fault_req_t             fault_queue [$];
    fault_result_t          predicted_maps [$];
    logic [PAGE_W-1:0]      seen_pages [$];

    int                     mismatches   = 0;
    int                     faults_sent  = 0;
    int                     results_seen = 0;
    int                     n_present    = 0;
    int                     n_evicted    = 0;
    int                     bases_used   = 0;
    int                     send_gap     = 0;
    bit                     send_burst   = 1'b0;
    int                     take_stall   = 0;
    bit                     take_burst   = 1'b0;
    int                     idle_cycles  = 0;

    mapped_page_fifo_table #(.SLOTS(SLOTS)) u_top
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic void note_mismatch(input string msg);
        mismatches++;
        if (mismatches <= 10)
            $display("MISMATCH: %s", msg);
    endfunction

    // Look up the page; on a miss fill the lowest free slot or evict the oldest.
    function automatic fault_result_t map_fault(input logic [VA_W-1:0] addr);
        logic [PAGE_W-1:0] vpn;
        fault_result_t     r;
        int                idx;
        vpn = addr[VA_W-1:PAGE_SHIFT];
        r = '0;
        for (int i = 0; i < SLOTS; i++)
        begin
            if (slot_valid[i] && slot_page[i] == vpn)
            begin
                n_present++;
                r.status        = 1'b1;
                r.slot          = SLOT_FIELD_W'(i);
                r.physical_page = {1'b0, frame_base} + PHYS_W'(i);
                return r;
            end
        end
        if (fill_count < SLOTS)
        begin
            idx = fill_count;
            fill_count++;
        end
        else
        begin
            idx = oldest_slot;
            if (slot_valid[idx])
            begin
                n_evicted++;
                r.evicted      = 1'b1;
                r.evicted_page = slot_page[idx];
            end
            oldest_slot = (idx + 1 < SLOTS) ? idx + 1 : 0;
        end
        slot_valid[idx] = 1'b1;
        slot_page[idx]  = vpn;
        r.slot          = SLOT_FIELD_W'(idx);
        r.physical_page = {1'b0, frame_base} + PHYS_W'(idx);
        return r;
    endfunction

    // Fault sender: gap only elapses while the block could take an item.
    always @(posedge clk)
    begin : fault_driver
        bit         taken;
        bit         offered;
        fault_req_t nxt;
        if (rst_n)
        begin
            taken   = s_tvalid && s_tready;
            offered = s_tvalid && !taken;
            if (taken)
            begin
                predicted_maps.push_back(map_fault(s_tdata));
                faults_sent++;
                if ($urandom_range(0, 39) == 0)
                    send_burst = !send_burst;
                send_gap = send_burst ? 0 : $urandom_range(0, MAX_WAIT);
            end
            else if (!offered && send_gap > 0 && (s_tready || predicted_maps.size() == 0))
                send_gap--;
            if (!offered)
            begin
                if (send_gap == 0 && fault_queue.size() != 0 &&
                    (!fault_queue[0].hold || predicted_maps.size() == 0))
                begin
                    nxt = fault_queue.pop_front();
                    s_tdata  <= nxt.addr;
                    s_tvalid <= 1'b1;
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin : map_monitor
        fault_result_t got;
        fault_result_t want;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                results_seen++;
                if (predicted_maps.size() == 0)
                    note_mismatch($sformatf("result with none expected: %h", m_tdata));
                else
                begin
                    want = predicted_maps.pop_front();
                    got  = fault_result_t'(m_tdata[RESULT_W-1:0]);
                    if (got.status !== want.status || got.slot !== want.slot ||
                        got.physical_page !== want.physical_page ||
                        got.evicted !== want.evicted || got.evicted_page !== want.evicted_page)
                        note_mismatch($sformatf(
                            {"result %0d exp st=%0d slot=%0d pp=%h ev=%0d evp=%h ",
                             "got st=%0d slot=%0d pp=%h ev=%0d evp=%h"},
                            results_seen, want.status, want.slot, want.physical_page,
                            want.evicted, want.evicted_page, got.status, got.slot,
                            got.physical_page, got.evicted, got.evicted_page));
                end
                if ($urandom_range(0, 39) == 0)
                    take_burst = !take_burst;
                take_stall = take_burst ? 0 : $urandom_range(0, MAX_WAIT);
                m_tready <= (take_stall == 0);
            end
            else if (m_tvalid && !m_tready)
            begin
                if (take_stall > 0)
                    take_stall--;
                if (take_stall == 0)
                    m_tready <= 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("watchdog: no transaction for %0d cycles", idle_cycles);
            $display("Regression FAIL");
            $finish;
        end
    end

    task automatic apb_xfer(input bit wr, input logic [APB_ADDR_W-1:0] addr,
                            input logic [APB_DATA_W-1:0] wdata,
                            output logic [APB_DATA_W-1:0] rdata);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= addr;
        pwdata  <= wdata;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        rdata = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Write a register (unmapped addresses must be ignored), then read the base back.
    task automatic set_register(input logic [APB_ADDR_W-1:0] addr,
                                input logic [BASE_W-1:0] value);
        logic [APB_DATA_W-1:0] rd;
        apb_xfer(1'b1, addr, APB_DATA_W'(value), rd);
        if (addr == REG_FRAME_BASE)
        begin
            frame_base = value;
            bases_used++;
        end
        apb_xfer(1'b0, REG_FRAME_BASE, '0, rd);
        if (rd !== APB_DATA_W'(frame_base))
            note_mismatch($sformatf("frame base read %h, expected %h", rd, frame_base));
    endtask

    task automatic wait_idle();
        while (fault_queue.size() != 0 || s_tvalid || predicted_maps.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic push_fault(input logic [VA_W-1:0] addr, input bit hold);
        fault_queue.push_back('{addr: addr, hold: hold});
    endtask

    task automatic run_phase(input logic [BASE_W-1:0] base, input int n_random,
                             input bit directed);
        int                r;
        logic [PAGE_W-1:0] vpn;
        wait_idle();
        set_register(REG_FRAME_BASE, base);
        if (directed)
        begin
            push_fault(64'h0000_0000_0000_0000, 1'b0);
            push_fault(64'h0000_0000_0000_0FFF, 1'b0);  // same page, other offset
            push_fault(64'hFFFF_FFFF_FFFF_FFFF, 1'b0);
            push_fault(64'hFFFF_FFFF_FFFF_F000, 1'b0);
            push_fault(64'h0000_0000_0000_1000, 1'b0);
            push_fault(64'h0000_0000_0000_0800, 1'b0);
            push_fault(64'h8000_0000_0000_0000, 1'b0);
            push_fault(64'h7FFF_FFFF_FFFF_FFFF, 1'b0);
            push_fault(64'hAAAA_AAAA_AAAA_AAAA, 1'b0);
            push_fault(64'h5555_5555_5555_5555, 1'b0);
            push_fault(64'hAAAA_AAAA_AAAA_A123, 1'b0);
            push_fault(64'hFFFF_FFFF_FFFF_E000, 1'b0);  // one bit off the top page
            push_fault(64'h0000_0000_0000_0FFF, 1'b1);
        end
        for (int n = 0; n < n_random; n++)
        begin
            r = $urandom_range(0, 99);
            if (r < 45 && seen_pages.size() != 0)
                vpn = seen_pages[$urandom_range(0, seen_pages.size() - 1)];
            else
            begin
                if (r < 60 && seen_pages.size() != 0)
                    vpn = seen_pages[$urandom_range(0, seen_pages.size() - 1)] ^
                          (PAGE_W'(1) << $urandom_range(0, PAGE_W - 1));
                else if (r < 94)
                    vpn = PAGE_W'({$urandom, $urandom});
                else if (r[0])
                    vpn = PAGE_W'($urandom_range(0, 3));
                else
                    vpn = ~PAGE_W'($urandom_range(0, 3));
                seen_pages.push_back(vpn);
                if (seen_pages.size() > HISTORY_LEN)
                    void'(seen_pages.pop_front());
            end
            push_fault({vpn, PAGE_SHIFT'($urandom)}, $urandom_range(0, 59) == 0);
        end
    endtask

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        run_phase('1, 400, 1'b1);
        run_phase('0, 350, 1'b0);
        wait_idle();
        set_register(~REG_FRAME_BASE, BASE_W'({$urandom, $urandom}));
        run_phase(BASE_W'({$urandom, $urandom}), 390, 1'b0);
        wait_idle();
        $display("Ran %0d faults, %0d results: %0d already present, %0d evictions",
                 faults_sent, results_seen, n_present, n_evicted);
        $display("Frame base programmed %0d times; %0d mismatches", bases_used, mismatches);
        if (mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
